/* rtl/ils_pkg.sv */
// Package for the indexed list store: opcodes, status codes and the
// controller-to-datapath command type. No dependencies.
package ils_pkg;

  localparam int OpW = 4;
  localparam int ValW = 32;
  localparam int PosW = 8;
  localparam int StW = 2;

  localparam logic [OpW-1:0] OpAddFirst = 4'd0;
  localparam logic [OpW-1:0] OpAddLast  = 4'd1;
  localparam logic [OpW-1:0] OpAddAt    = 4'd2;
  localparam logic [OpW-1:0] OpRemFirst = 4'd3;
  localparam logic [OpW-1:0] OpRemLast  = 4'd4;
  localparam logic [OpW-1:0] OpRemAt    = 4'd5;
  localparam logic [OpW-1:0] OpGetFirst = 4'd6;
  localparam logic [OpW-1:0] OpGetLast  = 4'd7;
  localparam logic [OpW-1:0] OpGetAt    = 4'd8;

  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StIndex = 2'd1;
  localparam logic [StW-1:0] StEmpty = 2'd2;
  localparam logic [StW-1:0] StFull  = 2'd3;

  // Command from controller to datapath
  typedef struct packed {
    logic exec;
  } ils_cmd_t;

endpackage

/* rtl/ils_in_if.sv */
// Request channel interface: valid/ready handshake with the request fields.
// Depends on ils_pkg.
interface ils_in_if;
  logic                       valid;
  logic                       ready;
  logic [ils_pkg::OpW-1:0]    opcode;
  logic signed [ils_pkg::ValW-1:0] value_in;
  logic [ils_pkg::PosW-1:0]   position;

  modport source (output valid, opcode, value_in, position, input ready);
  modport sink (input valid, opcode, value_in, position, output ready);
endinterface

/* rtl/ils_out_if.sv */
// Response channel interface: valid/ready handshake with the response fields.
// Depends on ils_pkg.
interface ils_out_if #(
  parameter int CntW = 5
);
  logic                            valid;
  logic                            ready;
  logic signed [ils_pkg::ValW-1:0] value_out;
  logic [ils_pkg::StW-1:0]         status;
  logic [CntW-1:0]                 count_out;

  modport source (output valid, value_out, status, count_out, input ready);
  modport sink (input valid, value_out, status, count_out, output ready);
endinterface

/* rtl/ils_ctrl.sv */
// Controller for the indexed list store: takes one transaction, holds its
// response until taken. Depends on ils_pkg.
module ils_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ils_pkg::ils_cmd_t cmd_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SBusy = 1'b1;

  logic state_q, state_d;

  // Sequence request and response
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = SBusy;
        end
      end
      SBusy: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

endmodule

/* rtl/ils_dp.sv */
// Datapath for the indexed list store: row of shift cells, entry count and
// response registers. Depends on ils_pkg.
module ils_dp #(
  parameter int DEPTH = 16,
  parameter int CntW  = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ils_pkg::ils_cmd_t               cmd_i,
  input  logic [ils_pkg::OpW-1:0]         opcode_i,
  input  logic signed [ils_pkg::ValW-1:0] value_in_i,
  input  logic [ils_pkg::PosW-1:0]        position_i,
  output logic signed [ils_pkg::ValW-1:0] value_out_o,
  output logic [ils_pkg::StW-1:0]         status_o,
  output logic [CntW-1:0]                 count_out_o
);

  localparam int CmpW = ((CntW > ils_pkg::PosW) ? CntW : ils_pkg::PosW) + 1;
  localparam int IdxW = $clog2(DEPTH);

  logic [ils_pkg::ValW-1:0] cell_q [DEPTH];
  logic [ils_pkg::ValW-1:0] cell_d [DEPTH];
  logic [CntW-1:0]          count_q, count_d;
  logic [ils_pkg::ValW-1:0] res_q, res_d;
  logic [ils_pkg::StW-1:0]  st_q, st_d;

  logic            is_add, is_rem, is_get, is_end, use_pos, is_last;
  logic [CmpW-1:0] cnt_w, idx_w;
  logic [IdxW-1:0] idx;
  logic            do_ins, do_rem;

  // Decode the request and pick the index
  always_comb begin
    is_add  = (opcode_i == ils_pkg::OpAddFirst) || (opcode_i == ils_pkg::OpAddLast)
           || (opcode_i == ils_pkg::OpAddAt);
    is_rem  = (opcode_i == ils_pkg::OpRemFirst) || (opcode_i == ils_pkg::OpRemLast)
           || (opcode_i == ils_pkg::OpRemAt);
    is_get  = (opcode_i == ils_pkg::OpGetFirst) || (opcode_i == ils_pkg::OpGetLast)
           || (opcode_i == ils_pkg::OpGetAt);
    use_pos = (opcode_i == ils_pkg::OpAddAt) || (opcode_i == ils_pkg::OpRemAt)
           || (opcode_i == ils_pkg::OpGetAt);
    is_last = (opcode_i == ils_pkg::OpAddLast) || (opcode_i == ils_pkg::OpRemLast)
           || (opcode_i == ils_pkg::OpGetLast);
    is_end  = (is_rem || is_get) && !use_pos;
    cnt_w   = CmpW'(count_q);
    if (use_pos)       idx_w = CmpW'(position_i);
    else if (!is_last) idx_w = '0;
    else if (is_add)   idx_w = cnt_w;
    else               idx_w = cnt_w - CmpW'(1);
    idx = idx_w[IdxW-1:0];
  end

  // Check the request and update cells and count
  always_comb begin
    st_d    = ils_pkg::StOk;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    count_d = count_q;
    res_d   = '0;
    if (is_add) begin
      if (idx_w > cnt_w)                     st_d = ils_pkg::StIndex;
      else if (cnt_w >= CmpW'(DEPTH))        st_d = ils_pkg::StFull;
      else                                   do_ins = 1'b1;
    end else if (is_rem || is_get) begin
      if (is_end && count_q == '0)           st_d = ils_pkg::StEmpty;
      else if (idx_w >= cnt_w)               st_d = ils_pkg::StIndex;
      else begin
        res_d  = cell_q[idx];
        do_rem = is_rem;
      end
    end
    if (do_ins) count_d = count_q + CntW'(1);
    if (do_rem) count_d = count_q - CntW'(1);
    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins) begin
        if (CmpW'(i) == idx_w)                 cell_d[i] = value_in_i;
        else if (i > 0 && CmpW'(i) > idx_w)    cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
      end else if (do_rem) begin
        if (i < DEPTH - 1 && CmpW'(i) >= idx_w) cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Hold cells and response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) cell_q[i] <= cell_d[i];
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         count_q <= '0;
    else if (cmd_i.exec) count_q <= count_d;
  end

  assign value_out_o = res_q;
  assign status_o    = st_q;
  assign count_out_o = count_q;

endmodule

/* rtl/indexed_list_store.sv */
// Indexed list store: top level joining controller and datapath.
// Depends on ils_pkg, ils_in_if, ils_out_if, ils_ctrl, ils_dp.

// Ordered list of up to DEPTH signed 32-bit values in a row of shift cells.
// Each request inserts, removes or reads at the front, the back or an index
// and gets exactly one response with the value, a status and the new count.
// An accepted request updates the list and the response registers; the
// response is then held in the output register until taken, and the next
// request is accepted in the cycle after that, never before the last
// response is taken. A failing request leaves the list unchanged.
module indexed_list_store #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ils_in_if.sink      in_s,
  ils_out_if.source   out_s
);

  localparam int CntW = $clog2(DEPTH + 1);

  ils_pkg::ils_cmd_t cmd;

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .cmd_o       (cmd)
  );

  ils_dp #(
    .DEPTH (DEPTH),
    .CntW  (CntW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (in_s.opcode),
    .value_in_i  (in_s.value_in),
    .position_i  (in_s.position),
    .value_out_o (out_s.value_out),
    .status_o    (out_s.status),
    .count_out_o (out_s.count_out)
  );

endmodule

/* test/ils_tb_if.sv */
// Testbench-side note: the channel interfaces come from rtl/ils_in_if.sv and
// rtl/ils_out_if.sv; this file holds the list scoreboard checker.
// Depends on ils_pkg, ils_in_if, ils_out_if.
module ils_list_checker #(
  parameter int DEPTH = 16,
  parameter int CntW  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ils_in_if.sink      req_w,
  ils_out_if.sink     rsp_w,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct {
    logic signed [ils_pkg::ValW-1:0] value;
    logic [ils_pkg::StW-1:0]         status;
    logic [CntW-1:0]                 count;
  } list_rsp_t;

  logic signed [ils_pkg::ValW-1:0] shadow_list [$];
  list_rsp_t                       rsp_queue [$];
  int                              fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = rsp_queue.size();

  // Apply one request to the shadow list and return its response
  function automatic list_rsp_t apply_request(logic [ils_pkg::OpW-1:0] op,
                                              logic signed [ils_pkg::ValW-1:0] val,
                                              logic [ils_pkg::PosW-1:0] pos);
    list_rsp_t r;
    int n;
    int at;
    logic is_first, is_last, is_rem;
    n = shadow_list.size();
    r.value = '0;
    r.status = ils_pkg::StOk;
    at = -1;
    is_first = (op == ils_pkg::OpRemFirst) || (op == ils_pkg::OpGetFirst);
    is_last  = (op == ils_pkg::OpRemLast) || (op == ils_pkg::OpGetLast);
    is_rem   = (op == ils_pkg::OpRemFirst) || (op == ils_pkg::OpRemLast) ||
               (op == ils_pkg::OpRemAt);
    case (op)
      ils_pkg::OpAddFirst, ils_pkg::OpAddLast, ils_pkg::OpAddAt: begin
        at = (op == ils_pkg::OpAddFirst) ? 0 : (op == ils_pkg::OpAddLast) ? n : int'(pos);
        if (at > n) r.status = ils_pkg::StIndex;
        else if (n >= DEPTH) r.status = ils_pkg::StFull;
        else shadow_list.insert(at, val);
      end
      ils_pkg::OpRemFirst, ils_pkg::OpRemLast, ils_pkg::OpRemAt,
      ils_pkg::OpGetFirst, ils_pkg::OpGetLast, ils_pkg::OpGetAt: begin
        if ((is_first || is_last) && n == 0) r.status = ils_pkg::StEmpty;
        else begin
          at = is_first ? 0 : is_last ? n - 1 : int'(pos);
          if (at >= n) r.status = ils_pkg::StIndex;
          else begin
            r.value = shadow_list[at];
            if (is_rem) shadow_list.delete(at);
          end
        end
      end
      default: ;
    endcase
    r.count = CntW'(shadow_list.size());
    return r;
  endfunction

  // Predict on request transactions, compare on response transactions
  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t exp_rsp;
    if (!rst_ni) begin
      fail_cnt = 0;
    end else begin
      if (req_w.valid && req_w.ready)
        rsp_queue.push_back(apply_request(req_w.opcode, req_w.value_in, req_w.position));
      if (rsp_w.valid && rsp_w.ready) begin
        if (rsp_queue.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10) $display("unexpected response at %0t", $time);
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (exp_rsp.value !== rsp_w.value_out || exp_rsp.status !== rsp_w.status ||
              exp_rsp.count !== rsp_w.count_out) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10)
              $display("mismatch at %0t: exp val %0d st %0d cnt %0d, got val %0d st %0d cnt %0d",
                       $time, exp_rsp.value, exp_rsp.status, exp_rsp.count,
                       rsp_w.value_out, rsp_w.status, rsp_w.count_out);
          end
        end
      end
    end
  end
endmodule

/* test/tb.sv */
// Testbench top for indexed_list_store: drives requests, stalls responses and
// gives the verdict. Depends on ils_pkg, the channel interfaces, ils_list_checker.
module tb;

  localparam int DEPTH = 16;
  localparam int CntW  = 5;
  localparam int Limit = 400000;
  localparam int OpW   = ils_pkg::OpW;
  localparam int ValW  = ils_pkg::ValW;
  localparam int PosW  = ils_pkg::PosW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   cycle_cnt = 0;
  int   level = 0;
  bit   hold_rsp = 1'b0;

  ils_in_if req_ch ();
  ils_out_if #(.CntW(CntW)) rsp_ch ();

  indexed_list_store #(.DEPTH(DEPTH)) dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_s (req_ch.sink), .out_s (rsp_ch.source)
  );

  ils_list_checker #(.DEPTH(DEPTH), .CntW(CntW)) u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_w (req_ch.sink), .rsp_w (rsp_ch.sink),
    .fail_cnt_o (fail_cnt), .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.value_in = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
  end

  // Abort on a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > Limit) begin
      $display("** indexed_list_store: FAILED **");
      $finish;
    end
  end

  // Send one request transaction after a random gap; valid stays high after
  // the handshake until the caller drops it or the next gap starts
  task automatic send_req(logic [OpW-1:0] op, logic signed [ValW-1:0] val,
                          int pos, int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.value_in <= val;
    req_ch.position <= PosW'(pos);
    do @(posedge clk_i); while (!req_ch.ready);
    // track list size to steer the random mix
    if (op <= ils_pkg::OpAddAt && level < DEPTH) level++;
    else if (op >= ils_pkg::OpRemFirst && op <= ils_pkg::OpRemAt && level > 0) level--;
  endtask

  // Pick a position mostly inside the list, sometimes just past it or random
  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return PosW'($urandom);
      1: return PosW'(level);
      2: return PosW'(level + 1);
      default: return PosW'($urandom_range(0, level));
    endcase
  endfunction

  // Response side: draw a wait before each transaction, hold off while hold_rsp is set
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall > 0 || hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_rsp) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  initial begin
    logic [OpW-1:0] op;
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty list, fill, overflow, extremes, removals
    send_req(ils_pkg::OpRemFirst, 0, 0, 0);
    send_req(ils_pkg::OpGetLast, 0, 0, 0);
    send_req(ils_pkg::OpGetAt, 0, 0, 0);
    send_req(ils_pkg::OpRemAt, 0, 255, 0);
    send_req(ils_pkg::OpAddAt, 32'sh7FFFFFFF, 1, 0);
    send_req(ils_pkg::OpAddAt, 32'sh80000000, 0, 0);
    send_req(ils_pkg::OpAddFirst, -1, 0, 0);
    send_req(ils_pkg::OpAddLast, 32'sh55555555, 0, 0);
    send_req(ils_pkg::OpAddAt, 32'shAAAAAAAA, 2, 0);
    for (k = 0; k < 12; k++) send_req(ils_pkg::OpAddLast, k, 0, 0);
    send_req(ils_pkg::OpAddFirst, 9, 0, 0);
    send_req(ils_pkg::OpAddAt, 9, 17, 0);
    send_req(ils_pkg::OpGetFirst, 0, 0, 0);
    send_req(ils_pkg::OpGetAt, 0, 15, 0);
    send_req(OpW'((1 << OpW) - 1), 0, 0, 0);
    send_req(ils_pkg::OpRemLast, 0, 0, 0);
    send_req(ils_pkg::OpRemAt, 0, 3, 0);
    send_req(ils_pkg::OpGetLast, 0, 0, 0);
    // long receiver hold-off while requests keep coming
    hold_rsp = 1'b1;
    fork
      begin repeat (60) @(posedge clk_i); hold_rsp = 1'b0; end
      for (k = 0; k < 6; k++) send_req(ils_pkg::OpGetAt, 0, pick_pos(), 0);
    join
    // random mix, with a pause until drained every so often
    for (k = 0; k < 1150; k++) begin
      if (k % 300 == 150) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
      end
      case ($urandom_range(0, 19))
        0: op = OpW'($urandom_range(int'(ils_pkg::OpGetAt) + 1, (1 << OpW) - 1));
        1, 2, 3, 4, 5, 6:
          op = (level > 13 && $urandom_range(0, 1)) ? ils_pkg::OpRemAt :
               OpW'($urandom_range(int'(ils_pkg::OpAddFirst), int'(ils_pkg::OpAddAt)));
        7, 8, 9, 10, 11, 12:
          op = (level < 3 && $urandom_range(0, 1)) ? ils_pkg::OpAddAt :
               OpW'($urandom_range(int'(ils_pkg::OpRemFirst), int'(ils_pkg::OpRemAt)));
        default:
          op = OpW'($urandom_range(int'(ils_pkg::OpGetFirst), int'(ils_pkg::OpGetAt)));
      endcase
      send_req(op, $urandom, pick_pos(), $urandom_range(0, 8) * $urandom_range(0, 1));
    end
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) $display("** indexed_list_store: PASSED **");
    else $display("** indexed_list_store: FAILED **");
    $finish;
  end
endmodule
